// ===== design/integer_to_radix_text_defines.svh =====
// assertion macros for the integer_to_radix_text checker
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define ITRT_ASSERT_NOW(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("itrt check failed");

// next-cycle implication, sampled on the rising clock edge
`define ITRT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("itrt check failed");

`endif

// ===== design/itrt_pkg.sv =====
// shared constants, types and command/status bundles for integer_to_radix_text
package itrt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVW       = DIV_STEPS * DIV_BITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W     = $clog2(VALUE_BITS);
  localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [DIGIT_W-1:0] DIGIT_LETTER_BASE = DIGIT_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [RADIX_W-1:0]           radix_t;
  typedef logic [CHAR_W-1:0]            char_t;

  typedef enum logic [1:0] {
    OSEL_SIGN,
    OSEL_DIGIT,
    OSEL_NUL
  } osel_t;

  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  digit_wr;
    logic  rd_issue;
    logic  out_load;
    osel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic quot_zero;
    logic cnt_zero;
    logic neg_dec;
    logic out_free;
  } sts_t;

endpackage

// ===== design/itrt_in_if.sv =====
// request channel carrying the integer to convert
interface itrt_in_if;
  import itrt_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/itrt_out_if.sv =====
// result channel carrying one text character per transfer
interface itrt_out_if;
  import itrt_pkg::*;

  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

// ===== design/itrt_cfg_if.sv =====
// configuration write channel for the radix register
interface itrt_cfg_if;
  import itrt_pkg::*;

  logic   valid;
  logic   ready;
  radix_t radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ===== design/itrt_datapath.sv =====
// datapath: radix register, chunked divider, digit store and output register
module itrt_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  itrt_pkg::cmd_t   cmd,
  output itrt_pkg::sts_t   sts,
  input  itrt_pkg::value_t in_value,
  input  logic             cfg_we,
  input  itrt_pkg::radix_t cfg_radix,
  input  logic             out_ready,
  output logic             out_valid,
  output itrt_pkg::char_t  out_text_char,
  output logic             out_last
);
  import itrt_pkg::*;

  radix_t               radix_r;
  logic [DIVW-1:0]      quot_r, quot_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_dec;
  logic                 neg_dec_r;
  logic [DIGIT_W-1:0]   digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]   rd_data_r;
  logic                 out_valid_r;
  char_t                text_char_r, char_nxt;
  logic                 last_r;
  logic                 in_neg;
  logic [VALUE_BITS-1:0] mag;

  function automatic char_t digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_LETTER_BASE) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_LETTER_BASE);
  endfunction

  assign in_neg  = in_value[VALUE_BITS-1];
  assign mag     = in_neg ? (~$unsigned(in_value) + 1'b1) : $unsigned(in_value);
  assign cnt_dec = cnt_r - CNT_W'(1);

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    logic [DIVW-1:0]    q;
    r = rem_r;
    q = quot_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r, q[DIVW-1]};
      q = {q[DIVW-2:0], 1'b0};
      if (trial >= {1'b0, radix_r}) begin
        trial = trial - {1'b0, radix_r};
        q[0] = 1'b1;
      end
      r = trial[DIGIT_W-1:0];
    end
    rem_nxt  = r;
    quot_nxt = q;
  end

  always_comb begin
    case (cmd.out_sel)
      OSEL_SIGN:  char_nxt = CHAR_MINUS;
      OSEL_DIGIT: char_nxt = digit_char(rd_data_r);
      default:    char_nxt = CHAR_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      cnt_r       <= '0;
      neg_dec_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_radix;
      end
      if (cmd.load) begin
        cnt_r     <= '0;
        neg_dec_r <= in_neg && (radix_r == RADIX_DEC);
      end else if (cmd.digit_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.rd_issue) begin
        cnt_r <= cnt_dec;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= DIVW'(mag);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end else if (cmd.digit_wr) begin
      rem_r <= '0;
    end
    if (cmd.out_load) begin
      text_char_r <= char_nxt;
      last_r      <= (cmd.out_sel == OSEL_NUL);
    end
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (cmd.digit_wr) begin
      digit_mem[cnt_r[ADDR_W-1:0]] <= rem_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= digit_mem[cnt_dec[ADDR_W-1:0]];
    end
  end

  assign sts.radix_ok  = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign sts.quot_zero = (quot_r == '0);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.neg_dec   = neg_dec_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_text_char = text_char_r;
  assign out_last      = last_r;
endmodule

// ===== design/itrt_ctrl.sv =====
// controller: sequences division, sign, digit readback and terminator
module itrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  itrt_pkg::sts_t sts,
  output itrt_pkg::cmd_t cmd
);
  import itrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIGIT,
    S_SIGN,
    S_READ,
    S_PUT,
    S_TERM
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.out_sel = OSEL_NUL;
    unique case (state_r)
      S_IDLE:  cmd.load     = accept && sts.radix_ok;
      S_DIV:   cmd.div_step = 1'b1;
      S_DIGIT: cmd.digit_wr = 1'b1;
      S_SIGN: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OSEL_SIGN;
      end
      S_READ:  cmd.rd_issue = 1'b1;
      S_PUT: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OSEL_DIGIT;
      end
      S_TERM: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OSEL_NUL;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (accept) begin
            state_r <= sts.radix_ok ? S_DIV : S_TERM;
          end
        end
        S_DIV: begin
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            step_r  <= '0;
            state_r <= S_DIGIT;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_DIGIT: begin
          // quotient already sits in the dividend register
          if (!sts.quot_zero) begin
            state_r <= S_DIV;
          end else if (sts.neg_dec) begin
            state_r <= S_SIGN;
          end else begin
            state_r <= S_READ;
          end
        end
        S_SIGN: if (sts.out_free) state_r <= S_READ;
        S_READ: state_r <= S_PUT;
        S_PUT: begin
          if (sts.out_free) begin
            state_r <= sts.cnt_zero ? S_TERM : S_READ;
          end
        end
        S_TERM: if (sts.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/integer_to_radix_text.sv =====
// top level: signed integer to ascii text in a configurable radix
//
//  channel | dir | payload              | handshake
//  in_if   | in  | value[31:0] signed   | valid/ready
//  out_if  | out | text_char[7:0], last | valid/ready
//  cfg_if  | in  | radix[5:0]           | valid/ready (ready held high)
//
// each digit: the divider works through the quotient in 8-bit chunks, then a store step
// readback reads each digit from the registered digit store, then outputs it; a sign
// and the terminator are output loads of their own; one request at a time
// a bad radix goes straight to the terminator
// output stalls hold the controller; the next request is taken once the
// terminator sits in the output register
// synchronous active-low reset, radix resets to 10
module integer_to_radix_text (
  input  logic       clk,
  input  logic       rst_n,
  itrt_in_if.sink    in_if,
  itrt_out_if.source out_if,
  itrt_cfg_if.sink   cfg_if
);
  import itrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_if.ready = 1'b1;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_if.value),
    .cfg_we        (cfg_if.valid),
    .cfg_radix     (cfg_if.radix),
    .out_ready     (out_if.ready),
    .out_valid     (out_if.valid),
    .out_text_char (out_if.text_char),
    .out_last      (out_if.last)
  );
endmodule

// ===== design/itrt_check.sv =====
// port-level checker for integer_to_radix_text and its bind
`include "integer_to_radix_text_defines.svh"

module itrt_check (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input itrt_pkg::char_t out_text_char,
  input logic            out_last
);
  import itrt_pkg::*;

  `ITRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_text_char) && $stable(out_last))
  `ITRT_ASSERT_NOW(a_nul_is_last, clk, rst_n, out_valid, (out_text_char == CHAR_NUL) == out_last)
  `ITRT_ASSERT_NOW(a_busy_mid_string, clk, rst_n, out_valid && !out_last, !in_ready)
  `ITRT_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind integer_to_radix_text itrt_check u_itrt_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_text_char (out_if.text_char),
  .out_last      (out_if.last)
);

// ===== tb/radix_text_monitor.sv =====
// scoreboard for integer_to_radix_text: predicts each request's text and checks every character
module radix_text_monitor
  import itrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  itrt_in_if   in_ch,
  itrt_out_if  out_ch,
  itrt_cfg_if  cfg_ch,
  output int   mismatches,
  output int   text_pending
);

  typedef struct packed {
    char_t glyph;
    logic  last;
  } text_item_t;

  text_item_t expected_text[$];
  radix_t     radix_now;

  initial begin
    mismatches   = 0;
    text_pending = 0;
    radix_now    = RADIX_RESET;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic char_t digit_glyph(logic [DIGIT_W-1:0] digit);
    if (digit < DIGIT_LETTER_BASE) begin
      return char_t'(CHAR_ZERO + digit);
    end
    return char_t'(CHAR_A + (digit - DIGIT_LETTER_BASE));
  endfunction

  // appends the whole string for one request, terminator included
  function automatic void predict_text(value_t v);
    logic [VALUE_BITS-1:0] magnitude;
    char_t                 digits[$];
    if (radix_now < RADIX_MIN || radix_now > RADIX_MAX) begin
      expected_text.push_back('{glyph: CHAR_NUL, last: 1'b1});
      return;
    end
    // two's complement negate, so the most negative value keeps its magnitude
    magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(digit_glyph(DIGIT_W'(magnitude % radix_now)));
      magnitude = magnitude / radix_now;
    end while (magnitude != 0);
    if (v[VALUE_BITS-1] && radix_now == RADIX_DEC) begin
      expected_text.push_back('{glyph: CHAR_MINUS, last: 1'b0});
    end
    foreach (digits[i]) begin
      expected_text.push_back('{glyph: digits[i], last: 1'b0});
    end
    expected_text.push_back('{glyph: CHAR_NUL, last: 1'b1});
  endfunction

  always @(posedge clk) begin
    text_item_t want;
    if (!rst_n) begin
      radix_now = RADIX_RESET;
      expected_text.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        radix_now = cfg_ch.radix;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with no text pending",
                                    out_ch.text_char));
        end else begin
          want = expected_text.pop_front();
          if (out_ch.text_char !== want.glyph) begin
            report_mismatch($sformatf("text_char 0x%02h, want 0x%02h",
                                      out_ch.text_char, want.glyph));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b on char 0x%02h",
                                      out_ch.last, want.last, want.glyph));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value);
      end
    end
    text_pending = expected_text.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the integer_to_radix_text regression: clock, reset, requests, radix writes, verdict
module testbench;
  import itrt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 21;

  logic clk;
  logic rst_n;
  int   cycles;
  int   mismatches;
  int   text_pending;
  bit   calm;

  itrt_in_if  in_ch();
  itrt_out_if out_ch();
  itrt_cfg_if cfg_ch();

  integer_to_radix_text u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  radix_text_monitor u_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .mismatches   (mismatches),
    .text_pending (text_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: ready stays high until a character is taken, then may drop for a random stall (none in calm phases)
  initial begin
    int stall;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        stall = calm ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_value(value_t v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sampled on the falling edge so the scoreboard has settled
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (text_pending != 0);
    @(posedge clk);
  endtask

  task automatic write_radix(radix_t r);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic value_t random_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return value_t'($urandom);
      3:       return value_t'($urandom_range(0, 999));
      4:       return -value_t'($urandom_range(1, 999));
      5: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '0;
          3:       return '1;
          default: return 32'h0000_0001;
        endcase
      end
      6:       return value_t'($urandom >> $urandom_range(0, 31));
      default: return -value_t'($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    radix_t phase_radix;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.radix <= '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // decimal straight out of reset, sign handling and the most negative value
    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'sd10);

    // binary gives the longest strings
    write_radix(RADIX_MIN);
    send_value(32'h8000_0000);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'd1);

    write_radix(RADIX_MAX);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(-32'sd35);

    // negatives outside decimal carry no sign
    write_radix(6'd16);
    send_value(32'hdead_beef);
    send_value(-32'sd1);

    // bad radix values: terminator only
    write_radix(6'd0);
    send_value(32'd5);
    write_radix(6'd1);
    send_value(-32'sd7);
    write_radix(6'd37);
    send_value(32'd0);
    write_radix(6'd63);
    send_value(32'h8000_0000);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_radix = RADIX_DEC;
        1:       phase_radix = RADIX_MIN;
        2:       phase_radix = RADIX_MAX;
        3:       phase_radix = 6'd8;
        4:       phase_radix = 6'd16;
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            phase_radix = radix_t'($urandom_range(0, 63));
          end else begin
            phase_radix = radix_t'($urandom_range(2, 36));
          end
        end
      endcase
      write_radix(phase_radix);
      calm = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_value(random_value());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && text_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
